// ===== rtl/lpkv_pkg.sv =====
// Package for the linear probing key-value store: command and status codes,
// sequencer states, register indexes and mixer constants. No dependencies.
`timescale 1ns / 1ps

package lpkv_pkg;

	localparam int CMD_W     = 3;
	localparam int KEY_W     = 64;
	localparam int VAL_IO_W  = 32;
	localparam int CFG_IDX_W = 2;
	localparam int CFG_DAT_W = 64;

	localparam logic [63:0] MIX_MUL = 64'ha24baed4963ee407;
	localparam int          ROT_A   = 25;
	localparam int          ROT_B   = 50;
	localparam int          MOD_STEPS = 4;

	typedef enum logic [CMD_W-1:0] {
		CMD_LOOKUP  = 3'd0,
		CMD_SET     = 3'd1,
		CMD_ADD     = 3'd2,
		CMD_SET_MIN = 3'd3,
		CMD_GET_INS = 3'd4,
		CMD_CLEAR   = 3'd5
	} cmd_t;

	typedef enum logic [1:0] {
		ST_PRESENT  = 2'd0,
		ST_INSERTED = 2'd1,
		ST_ABSENT   = 2'd2,
		ST_FULL     = 2'd3
	} status_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_SALT       = 2'd0,
		REG_MIX_ENABLE = 2'd1
	} reg_idx_t;

	typedef enum logic [3:0] {
		S_CLR,
		S_IDLE,
		S_MUL,
		S_SUM,
		S_HASH,
		S_MOD,
		S_QUO,
		S_REM,
		S_RD,
		S_CHK,
		S_EXEC
	} fsm_t;

endpackage

// ===== rtl/lpkv_if.sv =====
// Channel interfaces of the key-value store: command, result and register write.
// Depends on lpkv_pkg.
`timescale 1ns / 1ps

interface lpkv_cmd_if;
	logic                                valid;
	logic                                ready;
	logic [lpkv_pkg::CMD_W-1:0]          command;
	logic [lpkv_pkg::KEY_W-1:0]          key;
	logic signed [lpkv_pkg::VAL_IO_W-1:0] value;
	modport source (output valid, command, key, value, input ready);
	modport sink (input valid, command, key, value, output ready);
endinterface

interface lpkv_res_if #(parameter int CNT_W = 10);
	logic                                 valid;
	logic                                 ready;
	logic signed [lpkv_pkg::VAL_IO_W-1:0] value_out;
	logic [1:0]                           status;
	logic                                 updated;
	logic [CNT_W-1:0]                     entry_count;
	modport source (output valid, value_out, status, updated, entry_count, input ready);
	modport sink (input valid, value_out, status, updated, entry_count, output ready);
endinterface

interface lpkv_cfg_if;
	logic                               valid;
	logic                               ready;
	logic [lpkv_pkg::CFG_IDX_W-1:0]     index;
	logic [lpkv_pkg::CFG_DAT_W-1:0]     data;
	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

// ===== rtl/lpkv_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps

module lpkv_ram #(
	parameter int WIDTH = 64,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

// ===== rtl/linear_probe_key_value_store.sv =====
// Key-value store, 64-bit keys, open addressing with linear probing in a key RAM and a
// value RAM (one read and one write port each). An item first forms the home slot
// (salted rotate-xor-multiply mixer over four 32x32 partial products), then, when SLOTS
// is not a power of two, reduces it (four folds of the upper word, a reciprocal
// multiply and a subtract), then reads the home slot, probes slot by slot and updates;
// key 0, clear and the unused codes skip the mixer and the probe.
// After reset and after each clear the key RAM is swept to empty, during which no
// command word is taken. A new key is refused once SLOTS/2 keys are stored.
// Depends on lpkv_pkg, lpkv_if.sv and lpkv_ram.
`timescale 1ns / 1ps

module linear_probe_key_value_store #(
	parameter int SLOTS      = 1024,
	parameter int VALUE_BITS = 32,
	parameter int CNT_W      = $clog2(SLOTS / 2 + 1)
) (
	input  logic             clk,
	input  logic             arst_n,
	lpkv_cmd_if.sink         in_ch,
	lpkv_res_if.source       out_ch,
	lpkv_cfg_if.sink         cfg
);

	localparam int IDX_W = $clog2(SLOTS);
	localparam bit POW2  = (SLOTS & (SLOTS - 1)) == 0;
	localparam logic [CNT_W-1:0] HALF = CNT_W'(SLOTS / 2);
	localparam logic [IDX_W-1:0] LAST = IDX_W'(SLOTS - 1);
	// 2^32 mod SLOTS, and ceil(2^(32+IDX_W) / SLOTS) for an exact 32-bit quotient
	localparam logic [63:0] C32   = (64'd1 << 32) % 64'(SLOTS);
	localparam logic [63:0] RECIP = ((64'd1 << (32 + IDX_W)) + 64'(SLOTS) - 64'd1)
	                                / 64'(SLOTS);

	lpkv_pkg::fsm_t state_q, state_nx;

	logic [63:0]            salt_q;
	logic                   mix_q;
	logic [2:0]             cmd_q;
	logic [63:0]            key_q;
	logic [VALUE_BITS-1:0]  val_q;
	logic [63:0]            p00_q, p10_q, p01_q, p11_q, hip_q, h_q;
	logic [33:0]            mid_q;
	logic [31:0]            quo_q;
	logic [5:0]             mcnt_q;
	logic [IDX_W-1:0]       pos_q, clr_q;
	logic                   hit_q;
	logic [VALUE_BITS-1:0]  vcur_q;
	logic                   zkp_q;
	logic [VALUE_BITS-1:0]  zkv_q;
	logic [CNT_W-1:0]       cnt_q;
	logic                   ov_q;
	logic [31:0]            ores_q;
	logic [1:0]             ost_q;
	logic                   oupd_q;
	logic [CNT_W-1:0]       ocnt_q;

	// ram ports
	logic                  k_we, v_we;
	logic [IDX_W-1:0]      k_waddr, raddr;
	logic [63:0]           k_wdata, k_rdata;
	logic [VALUE_BITS-1:0] v_wdata, v_rdata;

	lpkv_ram #(.WIDTH(64), .DEPTH(SLOTS)) u_keys (
		.clk(clk), .we(k_we), .waddr(k_waddr), .wdata(k_wdata),
		.raddr(raddr), .rdata(k_rdata)
	);

	lpkv_ram #(.WIDTH(VALUE_BITS), .DEPTH(SLOTS)) u_vals (
		.clk(clk), .we(v_we), .waddr(pos_q), .wdata(v_wdata),
		.raddr(raddr), .rdata(v_rdata)
	);

	// input value: sign-extend from 32 bits, then truncate
	logic [63:0] in_ext;
	assign in_ext = 64'($signed(in_ch.value));

	// mixer front end
	logic [63:0] ks, kk;
	assign ks = key_q ^ salt_q;
	assign kk = ks ^ ((ks << lpkv_pkg::ROT_A) | (ks >> (64 - lpkv_pkg::ROT_A)))
	               ^ ((ks << lpkv_pkg::ROT_B) | (ks >> (64 - lpkv_pkg::ROT_B)));

	logic [63:0] hash;
	assign hash = mix_q ? ({mid_q[31:0], p00_q[31:0]} ^ (hip_q + 64'(mid_q[33:32])))
	                    : key_q;

	logic [IDX_W-1:0] pos_inc;
	assign pos_inc = (pos_q == LAST) ? '0 : pos_q + 1'b1;

	logic k_empty, k_hit;
	assign k_empty = (k_rdata == 64'd0);
	assign k_hit   = (k_rdata == key_q);

	logic out_free;
	assign out_free = !ov_q || out_ch.ready;

	// execute step
	logic                  key0, present, exec_fire, cnt_inc, wr_val, upd;
	logic [VALUE_BITS-1:0] cur, nval;
	logic [1:0]            st;
	logic [63:0]           res_ext;

	always_comb begin
		key0     = (key_q == 64'd0);
		present  = key0 ? zkp_q : hit_q;
		cur      = key0 ? zkv_q : vcur_q;
		nval     = cur;
		upd      = 1'b0;
		wr_val   = 1'b0;
		cnt_inc  = 1'b0;
		st       = lpkv_pkg::ST_PRESENT;
		case (cmd_q)
			lpkv_pkg::CMD_SET:     nval = val_q;
			lpkv_pkg::CMD_ADD:     nval = cur + val_q;
			lpkv_pkg::CMD_SET_MIN: begin
				if ($signed(val_q) < $signed(cur)) begin
					nval = val_q;
					upd  = 1'b1;
				end
			end
			default: nval = cur;
		endcase
		if (cmd_q == lpkv_pkg::CMD_CLEAR) begin
			nval = '0;
			upd  = 1'b0;
		end else if (cmd_q > lpkv_pkg::CMD_CLEAR) begin
			nval = '0;
			upd  = 1'b0;
			st   = lpkv_pkg::ST_ABSENT;
		end else if (present) begin
			wr_val = 1'b1;
		end else if (cmd_q == lpkv_pkg::CMD_LOOKUP) begin
			nval = val_q;
			upd  = 1'b0;
			st   = lpkv_pkg::ST_ABSENT;
		end else if (cnt_q >= HALF) begin
			nval = '0;
			upd  = 1'b0;
			st   = lpkv_pkg::ST_FULL;
		end else begin
			nval    = (cmd_q == lpkv_pkg::CMD_GET_INS) ? '0 : val_q;
			upd     = 1'b0;
			wr_val  = 1'b1;
			cnt_inc = 1'b1;
			st      = lpkv_pkg::ST_INSERTED;
		end
		res_ext = 64'($signed(nval));
	end

	assign exec_fire = (state_q == lpkv_pkg::S_EXEC) && out_free;

	// next state and RAM control
	always_comb begin
		state_nx = state_q;
		raddr    = pos_q;
		k_we     = 1'b0;
		k_waddr  = pos_q;
		k_wdata  = key_q;
		v_we     = 1'b0;
		v_wdata  = nval;
		case (state_q)
			lpkv_pkg::S_CLR: begin
				k_we    = 1'b1;
				k_waddr = clr_q;
				k_wdata = 64'd0;
				if (clr_q == LAST) begin
					state_nx = lpkv_pkg::S_IDLE;
				end
			end
			lpkv_pkg::S_IDLE: begin
				if (in_ch.valid) begin
					if (in_ch.command >= lpkv_pkg::CMD_CLEAR || in_ch.key == 64'd0) begin
						state_nx = lpkv_pkg::S_EXEC;
					end else begin
						state_nx = lpkv_pkg::S_MUL;
					end
				end
			end
			lpkv_pkg::S_MUL:  state_nx = lpkv_pkg::S_SUM;
			lpkv_pkg::S_SUM:  state_nx = lpkv_pkg::S_HASH;
			lpkv_pkg::S_HASH: state_nx = POW2 ? lpkv_pkg::S_RD : lpkv_pkg::S_MOD;
			lpkv_pkg::S_MOD: begin
				if (mcnt_q == 6'(lpkv_pkg::MOD_STEPS - 1)) begin
					state_nx = lpkv_pkg::S_QUO;
				end
			end
			lpkv_pkg::S_QUO:  state_nx = lpkv_pkg::S_REM;
			lpkv_pkg::S_REM:  state_nx = lpkv_pkg::S_RD;
			lpkv_pkg::S_RD:   state_nx = lpkv_pkg::S_CHK;
			lpkv_pkg::S_CHK: begin
				if (k_empty || k_hit) begin
					state_nx = lpkv_pkg::S_EXEC;
				end else begin
					raddr = pos_inc;
				end
			end
			lpkv_pkg::S_EXEC: begin
				if (out_free) begin
					k_we = wr_val && cnt_inc && !key0;
					v_we = wr_val && !key0;
					state_nx = (cmd_q == lpkv_pkg::CMD_CLEAR) ? lpkv_pkg::S_CLR
					                                          : lpkv_pkg::S_IDLE;
				end
			end
			default: state_nx = lpkv_pkg::S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= lpkv_pkg::S_CLR;
		end else begin
			state_q <= state_nx;
		end
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			salt_q <= '0;
			mix_q  <= 1'b1;
			clr_q  <= '0;
			zkp_q  <= 1'b0;
			cnt_q  <= '0;
			ov_q   <= 1'b0;
			mcnt_q <= '0;
		end else begin
			if (cfg.valid) begin
				if (cfg.index == lpkv_pkg::REG_SALT) begin
					salt_q <= cfg.data;
				end else if (cfg.index == lpkv_pkg::REG_MIX_ENABLE) begin
					mix_q <= cfg.data[0];
				end
			end
			if (state_q == lpkv_pkg::S_CLR) begin
				clr_q <= (clr_q == LAST) ? '0 : clr_q + 1'b1;
			end
			if (state_q == lpkv_pkg::S_HASH) begin
				mcnt_q <= '0;
			end else if (state_q == lpkv_pkg::S_MOD) begin
				mcnt_q <= mcnt_q + 1'b1;
			end
			if (exec_fire) begin
				ov_q <= 1'b1;
				if (cmd_q == lpkv_pkg::CMD_CLEAR) begin
					cnt_q <= '0;
					zkp_q <= 1'b0;
				end else begin
					if (cnt_inc) begin
						cnt_q <= cnt_q + 1'b1;
					end
					if (cnt_inc && key0) begin
						zkp_q <= 1'b1;
					end
				end
			end else if (out_ch.ready) begin
				ov_q <= 1'b0;
			end
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		if (state_q == lpkv_pkg::S_IDLE && in_ch.valid) begin
			cmd_q <= in_ch.command;
			key_q <= in_ch.key;
			val_q <= in_ext[VALUE_BITS-1:0];
		end
		if (state_q == lpkv_pkg::S_MUL) begin
			p00_q <= 64'(kk[31:0])  * 64'(lpkv_pkg::MIX_MUL[31:0]);
			p10_q <= 64'(kk[63:32]) * 64'(lpkv_pkg::MIX_MUL[31:0]);
			p01_q <= 64'(kk[31:0])  * 64'(lpkv_pkg::MIX_MUL[63:32]);
			p11_q <= 64'(kk[63:32]) * 64'(lpkv_pkg::MIX_MUL[63:32]);
		end
		if (state_q == lpkv_pkg::S_SUM) begin
			mid_q <= 34'(p00_q[63:32]) + 34'(p10_q[31:0]) + 34'(p01_q[31:0]);
			hip_q <= p11_q + 64'(p10_q[63:32]) + 64'(p01_q[63:32]);
		end
		if (state_q == lpkv_pkg::S_HASH) begin
			h_q   <= hash;
			pos_q <= hash[IDX_W-1:0];
		end
		if (state_q == lpkv_pkg::S_MOD) begin
			// fold the upper word back in; four folds leave the value below 2^32
			h_q <= 64'(h_q[63:32]) * 64'(C32[16:0]) + 64'(h_q[31:0]);
		end
		if (state_q == lpkv_pkg::S_QUO) begin
			quo_q <= 32'((65'(h_q[31:0]) * 65'(RECIP[32:0])) >> (32 + IDX_W));
		end
		if (state_q == lpkv_pkg::S_REM) begin
			pos_q <= IDX_W'(h_q[31:0] - 32'(64'(quo_q) * 64'(SLOTS)));
		end
		if (state_q == lpkv_pkg::S_CHK) begin
			if (k_empty || k_hit) begin
				hit_q  <= k_hit && !k_empty;
				vcur_q <= v_rdata;
			end else begin
				pos_q <= pos_inc;
			end
		end
		if (exec_fire) begin
			if (wr_val && key0) begin
				zkv_q <= nval;
			end
			ores_q <= res_ext[31:0];
			ost_q  <= st;
			oupd_q <= upd;
			if (cmd_q == lpkv_pkg::CMD_CLEAR) begin
				ocnt_q <= '0;
			end else begin
				ocnt_q <= cnt_inc ? cnt_q + 1'b1 : cnt_q;
			end
		end
	end

	assign in_ch.ready        = (state_q == lpkv_pkg::S_IDLE);
	assign cfg.ready          = 1'b1;
	assign out_ch.valid       = ov_q;
	assign out_ch.value_out   = ores_q;
	assign out_ch.status      = ost_q;
	assign out_ch.updated     = oupd_q;
	assign out_ch.entry_count = ocnt_q;

	// checks
	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= HALF)
		else $error("stored count above half the slots");

	a_full_cnt: assert property (@(posedge clk) disable iff (!arst_n)
		ov_q && ost_q == lpkv_pkg::ST_FULL |-> ocnt_q == HALF)
		else $error("refusal below capacity");

	a_clear: assert property (@(posedge clk) disable iff (!arst_n)
		exec_fire && cmd_q == lpkv_pkg::CMD_CLEAR
		|=> state_q == lpkv_pkg::S_CLR && cnt_q == '0 && !zkp_q)
		else $error("clear did not start sweep");

	a_insert: assert property (@(posedge clk) disable iff (!arst_n)
		exec_fire && cnt_inc && cmd_q != lpkv_pkg::CMD_CLEAR
		|=> cnt_q == $past(cnt_q) + 1'b1)
		else $error("insert did not bump count");

endmodule

// ===== tb/lpkv_checker.sv =====
// Checker for the key-value store: watches command, result and register channels,
// predicts each result word and compares. Depends on lpkv_pkg and lpkv_if.sv.
`timescale 1ns / 1ps

module lpkv_checker (
	input  logic       clk,
	input  logic       arst_n,
	lpkv_cmd_if.sink   cmd_mon,
	lpkv_res_if.sink   res_mon,
	lpkv_cfg_if.sink   cfg_mon,
	output int         fail_count,
	output int         pending
);

	localparam int NSLOT = 1024;

	typedef struct packed {
		logic signed [31:0] value_out;
		logic [1:0]         status;
		logic               updated;
		logic [9:0]         entry_count;
	} result_t;

	logic [63:0]        salt_r;
	logic               mix_r;
	logic [63:0]        keys [NSLOT];
	logic [31:0]        vals [NSLOT];
	logic               zero_here;
	logic [31:0]        zero_val;
	int                 n_stored;
	result_t            expected_q[$];

	function automatic logic [63:0] rotl(logic [63:0] x, int r);
		return (x << r) | (x >> (64 - r));
	endfunction

	function automatic int home_slot(logic [63:0] k);
		logic [127:0] prod;
		logic [63:0]  h;
		if (!mix_r) return int'(k[9:0]);
		k = k ^ salt_r;
		k = k ^ rotl(k, 25) ^ rotl(k, 50);
		prod = {64'd0, k} * {64'd0, 64'ha24baed4963ee407};
		h = prod[63:0] ^ prod[127:64];
		return int'(h[9:0]);
	endfunction

	task automatic apply_cmd(logic [2:0] c, logic [63:0] k, logic [31:0] v);
		result_t r;
		int      p;
		logic    found, room;
		logic [31:0] cur;
		r = '0;
		found = 0;
		room = 0;
		p = 0;
		if (c == lpkv_pkg::CMD_CLEAR) begin
			foreach (keys[i]) keys[i] = '0;
			zero_here = 0;
			n_stored = 0;
		end else if (c > lpkv_pkg::CMD_CLEAR) begin
			r.status = lpkv_pkg::ST_ABSENT;
		end else begin
			if (k == 0) begin
				found = zero_here;
				room = 1;
				cur = zero_val;
			end else begin
				p = home_slot(k);
				for (int n = 0; n < NSLOT; n++) begin
					if (keys[p] == 0) begin
						room = 1;
						break;
					end
					if (keys[p] == k) begin
						found = 1;
						break;
					end
					p = (p + 1) % NSLOT;
				end
				cur = vals[p];
			end
			if (found) begin
				case (c)
					lpkv_pkg::CMD_SET: cur = v;
					lpkv_pkg::CMD_ADD: cur = cur + v;
					lpkv_pkg::CMD_SET_MIN: if ($signed(v) < $signed(cur)) begin
						cur = v;
						r.updated = 1;
					end
					default: ;
				endcase
				r.value_out = cur;
				r.status = lpkv_pkg::ST_PRESENT;
			end else if (c == lpkv_pkg::CMD_LOOKUP) begin
				r.value_out = v;
				r.status = lpkv_pkg::ST_ABSENT;
			end else if (!room || n_stored >= NSLOT / 2) begin
				r.status = lpkv_pkg::ST_FULL;
			end else begin
				cur = (c == lpkv_pkg::CMD_GET_INS) ? 32'd0 : v;
				if (k == 0) zero_here = 1;
				else keys[p] = k;
				n_stored++;
				r.value_out = cur;
				r.status = lpkv_pkg::ST_INSERTED;
			end
			if (k == 0) zero_val = cur;
			else if (found || r.status == lpkv_pkg::ST_INSERTED) vals[p] = cur;
		end
		r.entry_count = n_stored[9:0];
		expected_q.push_back(r);
	endtask

	always @(posedge clk or negedge arst_n) begin
		result_t got, want;
		if (!arst_n) begin
			salt_r = '0;
			mix_r = 1;
			foreach (keys[i]) keys[i] = '0;
			zero_here = 0;
			n_stored = 0;
			expected_q.delete();
			fail_count = 0;
			pending = 0;
		end else begin
			if (cfg_mon.valid && cfg_mon.ready) begin
				if (cfg_mon.index == lpkv_pkg::REG_SALT) salt_r = cfg_mon.data;
				else if (cfg_mon.index == lpkv_pkg::REG_MIX_ENABLE) mix_r = cfg_mon.data[0];
			end
			if (res_mon.valid && res_mon.ready) begin
				got = '{res_mon.value_out, res_mon.status, res_mon.updated,
					res_mon.entry_count};
				if (expected_q.size() == 0) begin
					fail_count++;
					if (fail_count <= 10)
						$display("unexpected result word %h", got);
				end else begin
					want = expected_q.pop_front();
					if (got !== want) begin
						fail_count++;
						if (fail_count <= 10)
							$display("mismatch: exp val=%0d st=%0d upd=%0d cnt=%0d, ",
								want.value_out, want.status, want.updated,
								want.entry_count,
								"got val=%0d st=%0d upd=%0d cnt=%0d",
								got.value_out, got.status, got.updated, got.entry_count);
					end
				end
			end
			// commands are predicted after the result check, so ordering is kept
			if (cmd_mon.valid && cmd_mon.ready)
				apply_cmd(cmd_mon.command, cmd_mon.key, cmd_mon.value);
			pending = expected_q.size();
		end
	end
endmodule

// ===== tb/tb_linear_probe_key_value_store.sv =====
// Top of the key-value store testbench: clock, reset, command and register stimulus,
// result back-pressure and verdict. Depends on lpkv_pkg, lpkv_if.sv and lpkv_checker.
`timescale 1ns / 1ps

module tb_linear_probe_key_value_store;

	logic clk;
	logic arst_n;
	int   fail_count;
	int   pending;
	logic calm;
	logic hold_long;

	lpkv_cmd_if cmd_ch ();
	lpkv_res_if #(.CNT_W(10)) res_ch ();
	lpkv_cfg_if cfg_ch ();

	linear_probe_key_value_store dut (
		.clk(clk), .arst_n(arst_n), .in_ch(cmd_ch.sink), .out_ch(res_ch.source),
		.cfg(cfg_ch.sink)
	);

	lpkv_checker chk (
		.clk(clk), .arst_n(arst_n), .cmd_mon(cmd_ch.sink), .res_mon(res_ch.sink),
		.cfg_mon(cfg_ch.sink), .fail_count(fail_count), .pending(pending)
	);

	logic [63:0] key_pool [16];

	initial begin
		clk = 0;
		forever #5 clk = ~clk;
	end

	initial begin
		#20ms;
		$display("Mismatches found");
		$finish;
	end

	// result side stall: random bursts, one long hold, none when calm
	initial begin
		int gap;
		res_ch.ready = 0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (hold_long) begin
				res_ch.ready <= 0;
				repeat (400) @(posedge clk);
				res_ch.ready <= 1;
				wait (!hold_long);
			end else if (!calm && $urandom_range(0, 5) == 0) begin
				gap = $urandom_range(1, 5);
				res_ch.ready <= 0;
				repeat (gap - 1) @(posedge clk);
			end else begin
				res_ch.ready <= 1;
			end
		end
	end

	task automatic write_reg(lpkv_pkg::reg_idx_t idx, logic [63:0] d);
		cfg_ch.valid <= 1;
		cfg_ch.index <= idx;
		cfg_ch.data  <= d;
		do @(posedge clk); while (!cfg_ch.ready);
		cfg_ch.valid <= 0;
	endtask

	task automatic send(lpkv_pkg::cmd_t c, logic [63:0] k, logic [31:0] v);
		if (!calm && $urandom_range(0, 4) == 0) begin
			cmd_ch.valid <= 0;
			repeat ($urandom_range(1, 5)) @(posedge clk);
		end
		cmd_ch.valid   <= 1;
		cmd_ch.command <= c;
		cmd_ch.key     <= k;
		cmd_ch.value   <= v;
		do @(posedge clk); while (!cmd_ch.ready);
	endtask

	task automatic drain();
		cmd_ch.valid <= 0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (100) @(posedge clk);
	endtask

	function automatic logic [63:0] rand64();
		return {$urandom(), $urandom()};
	endfunction

	function automatic logic [31:0] rand_val();
		case ($urandom_range(0, 5))
			0: return 32'h8000_0000;
			1: return 32'h7fff_ffff;
			2: return $urandom_range(0, 20) - 10;
			default: return $urandom();
		endcase
	endfunction

	task automatic random_phase(int count, int pool_n);
		lpkv_pkg::cmd_t c;
		logic [63:0] k;
		for (int i = 0; i < count; i++) begin
			c = lpkv_pkg::cmd_t'($urandom_range(0, 4));
			if ($urandom_range(0, 199) == 0) c = lpkv_pkg::CMD_CLEAR;
			case ($urandom_range(0, 9))
				0: k = rand64();
				1: k = 64'd0;
				default: k = key_pool[$urandom_range(0, pool_n - 1)];
			endcase
			send(c, k, rand_val());
		end
	endtask

	initial begin
		calm = 0;
		hold_long = 0;
		arst_n = 0;
		cmd_ch.valid = 0;
		cmd_ch.command = lpkv_pkg::CMD_LOOKUP;
		cmd_ch.key = '0;
		cmd_ch.value = '0;
		cfg_ch.valid = 0;
		cfg_ch.index = lpkv_pkg::REG_SALT;
		cfg_ch.data = '0;
		repeat (8) @(posedge clk);
		arst_n <= 1;
		foreach (key_pool[i]) key_pool[i] = rand64();
		key_pool[0] = 64'hffff_ffff_ffff_ffff;
		key_pool[1] = 64'd1;
		key_pool[2] = 64'h8000_0000_0000_0000;

		// directed: every command, extremes, key zero, unused codes, clear
		send(lpkv_pkg::CMD_LOOKUP, 64'd0, 32'h8000_0000);
		send(lpkv_pkg::CMD_GET_INS, 64'd0, 32'h1234);
		send(lpkv_pkg::CMD_SET, 64'hffff_ffff_ffff_ffff, 32'h7fff_ffff);
		send(lpkv_pkg::CMD_ADD, 64'hffff_ffff_ffff_ffff, 32'd1);
		send(lpkv_pkg::CMD_SET_MIN, 64'hffff_ffff_ffff_ffff, 32'h8000_0000);
		send(lpkv_pkg::CMD_SET_MIN, 64'hffff_ffff_ffff_ffff, 32'd5);
		send(lpkv_pkg::CMD_SET_MIN, 64'd7, 32'hffff_fff0);
		send(lpkv_pkg::CMD_ADD, 64'd0, 32'hffff_ffff);
		send(lpkv_pkg::CMD_LOOKUP, 64'd7, 32'd0);
		send(lpkv_pkg::CMD_GET_INS, 64'd7, 32'd9);
		send(lpkv_pkg::cmd_t'(3'd6), 64'd7, 32'd1);
		send(lpkv_pkg::cmd_t'(3'd7), 64'd0, 32'hffff_ffff);
		send(lpkv_pkg::CMD_CLEAR, 64'd7, 32'd0);
		send(lpkv_pkg::CMD_LOOKUP, 64'd7, 32'h5555_5555);
		drain();

		// raw key bits as slot: keys colliding on one home slot probe in a run
		write_reg(lpkv_pkg::REG_MIX_ENABLE, 64'd0);
		for (int i = 1; i <= 6; i++) send(lpkv_pkg::CMD_SET, 64'(i) << 10, 32'(i));
		for (int i = 6; i >= 1; i--) send(lpkv_pkg::CMD_LOOKUP, 64'(i) << 10, 32'd0);
		send(lpkv_pkg::CMD_SET, 64'h3ff, 32'd1);
		send(lpkv_pkg::CMD_SET, 64'h7ff, 32'd2);
		send(lpkv_pkg::CMD_LOOKUP, 64'hbff, 32'd3);
		drain();
		// mixer re-enabled and salt changed with keys stored: earlier keys may be missed
		write_reg(lpkv_pkg::REG_MIX_ENABLE, 64'd1);
		write_reg(lpkv_pkg::REG_SALT, 64'hffff_ffff_ffff_ffff);
		for (int i = 1; i <= 6; i++) send(lpkv_pkg::CMD_GET_INS, 64'(i) << 10, 32'd0);
		drain();

		// fill to capacity with refusals, long result stall meanwhile
		hold_long = 1;
		for (int i = 0; i < 530; i++)
			send(lpkv_pkg::CMD_SET, rand64() | 64'd1, rand_val());
		hold_long = 0;
		send(lpkv_pkg::CMD_GET_INS, 64'd0, 32'd0);
		send(lpkv_pkg::CMD_CLEAR, 64'd0, 32'd0);
		drain();

		write_reg(lpkv_pkg::REG_SALT, 64'd0);
		random_phase(600, 16);
		drain();
		write_reg(lpkv_pkg::REG_SALT, rand64());
		write_reg(lpkv_pkg::REG_MIX_ENABLE, 64'd0);
		random_phase(400, 16);
		drain();
		write_reg(lpkv_pkg::REG_MIX_ENABLE, 64'd1);
		calm = 1;
		random_phase(400, 8);
		drain();

		if (fail_count == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end
endmodule

// ===== sim.f =====
rtl/lpkv_pkg.sv
rtl/lpkv_if.sv
rtl/lpkv_ram.sv
rtl/linear_probe_key_value_store.sv
tb/lpkv_checker.sv
tb/tb_linear_probe_key_value_store.sv
